>>> rtl/ffba_pkg.sv
// Shared item types, status codes and register indexes of the block allocator.
`default_nettype none
package ffba_pkg;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BASE  = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_MEM    = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_NOT_BLOCK = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_LEAKED    = 3'd5
  } status_e;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_bytes;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] user_address;
    logic        swap_grant;
    logic [16:0] block_bytes;
    logic [17:0] spare_bytes;
  } rsp_t;

endpackage
`default_nettype wire

>>> rtl/ffba_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
`default_nettype none
module ffba_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator with free list and header store.
//
// Requests arrive on the input channel (valid/stall) as one item each: an
// allocate or a free. Every request gives exactly one result item on the
// output channel. The block handles one request at a time and stalls the
// input while it works; a finished result waits in an output register, so
// the next request is taken while the receiver stalls.
// An allocate scans the free list held in a RAM, one entry per cycle, and
// takes the first listed entry that fits; with no fit the block is cut from
// the unused end of the heap, else of the swap region. When the chosen entry
// is removed and entries follow it, they move up one per cycle. A free puts
// the new entry at the front, and the list moves down through the RAM.
// After reset, and after every configuration write, the header RAM is
// cleared one granule a cycle: (HEAP_MAX_BYTES + 7) / 8 + (SWAP_BYTES + 7) / 8
// granules, 16384 with the default sizes. No item is accepted meanwhile.
// Configuration is to be written only while the block is idle; the block does not enforce this.
`default_nettype none
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int HEADER_BYTES   = 40,
  parameter int HEAP_MAX_BYTES = 65536,
  parameter int SWAP_BYTES     = 65536,
  parameter int FREE_SLOTS     = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire req_t                 in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output rsp_t                      out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int MAXR   = (HEAP_MAX_BYTES > SWAP_BYTES) ? HEAP_MAX_BYTES : SWAP_BYTES;
  localparam int LEN_W  = $clog2(MAXR + 1);
  localparam int CW     = ((LEN_W > 18) ? LEN_W : 18) + 2;
  localparam int CNT_W  = $clog2(FREE_SLOTS + 1);
  localparam int IDX_W  = $clog2(FREE_SLOTS);
  localparam int HG     = (HEAP_MAX_BYTES + 7) / 8;
  localparam int SG     = (SWAP_BYTES + 7) / 8;
  localparam int GDEPTH = HG + SG;
  localparam int GA_W   = $clog2(GDEPTH);
  localparam int EW     = 2 * LEN_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_FIT  = 4'd2;
  localparam logic [3:0] S_SHD  = 4'd3;
  localparam logic [3:0] S_BUMP = 4'd4;
  localparam logic [3:0] S_HW   = 4'd5;
  localparam logic [3:0] S_FREG = 4'd6;
  localparam logic [3:0] S_FRD  = 4'd7;
  localparam logic [3:0] S_FHDR = 4'd8;
  localparam logic [3:0] S_SHU  = 4'd9;
  localparam logic [3:0] S_PUSH = 4'd10;
  localparam logic [3:0] S_RES  = 4'd11;

  localparam logic [32:0] SPAN = 33'h1_0000_0000;

  // Configuration and region lengths.
  logic [31:0]      heap_base_q, swap_base_q;
  logic [16:0]      heap_bytes_q;
  logic [LEN_W-1:0] heap_len_q, swap_len_q;
  logic [32:0]      hb_sat, heap_cut, swap_cut;
  logic             reinit;

  assign reinit = cfg_we_i && (cfg_index_i == CFG_HEAP_BASE ||
                  cfg_index_i == CFG_HEAP_BYTES || cfg_index_i == CFG_SWAP_BASE);

  always_comb begin
    hb_sat = (33'(heap_bytes_q) > 33'(HEAP_MAX_BYTES)) ? 33'(HEAP_MAX_BYTES)
                                                        : 33'(heap_bytes_q);
    heap_cut = (({1'b0, heap_base_q} + hb_sat) > SPAN) ? SPAN - {1'b0, heap_base_q}
                                                       : hb_sat;
    swap_cut = (({1'b0, swap_base_q} + 33'(SWAP_BYTES)) > SPAN) ?
               SPAN - {1'b0, swap_base_q} : 33'(SWAP_BYTES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      heap_bytes_q <= '0;
      swap_base_q  <= 32'h0001_0000;
      heap_len_q   <= '0;
      swap_len_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_HEAP_BASE:  heap_base_q  <= cfg_wdata_i;
          CFG_HEAP_BYTES: heap_bytes_q <= cfg_wdata_i[16:0];
          CFG_SWAP_BASE:  swap_base_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      heap_len_q <= LEN_W'(heap_cut);
      swap_len_q <= LEN_W'(swap_cut);
    end
  end

  // Control and datapath registers.
  logic [3:0]       state_q, state_d;
  req_t             req_q, req_d;
  logic [CW-1:0]    total_q, total_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, iss_q, iss_d;
  logic [LEN_W:0]   listed_q, listed_d;
  logic [LEN_W-1:0] hnext_q, hnext_d, snext_q, snext_d;
  logic [IDX_W-1:0] chk_q, chk_d, rdi_q, rdi_d, pidx_q, pidx_d;
  logic             pend_q, pend_d;
  logic [EW-1:0]    ent_q, ent_d;
  logic             swp_q, swp_d;
  logic [LEN_W-1:0] off_q, off_d, bytes_q, bytes_d;
  status_e          st_q, st_d;
  logic [31:0]      user_q, user_d;
  logic             fsw_q, fsw_d;
  logic [16:0]      bb_q, bb_d;
  logic             clr_q;
  logic [GA_W-1:0]  clr_addr_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  // RAM ports.
  logic             fl_we;
  logic [IDX_W-1:0] fl_waddr, fl_raddr;
  logic [EW-1:0]    fl_wdata, fl_rdata;
  logic             hd_we, ctl_hd_we;
  logic [GA_W-1:0]  hd_waddr, ctl_hd_waddr, hd_raddr;
  logic [LEN_W-1:0] hd_wdata, ctl_hd_wdata, hd_rdata;

  ffba_ram #(.W(EW), .DEPTH(FREE_SLOTS)) u_fl_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  ffba_ram #(.W(LEN_W), .DEPTH(GDEPTH)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hd_we),
    .waddr_i (hd_waddr),
    .wdata_i (hd_wdata),
    .raddr_i (hd_raddr),
    .rdata_o (hd_rdata)
  );

  assign hd_we    = clr_q | ctl_hd_we;
  assign hd_waddr = clr_q ? clr_addr_q : ctl_hd_waddr;
  assign hd_wdata = clr_q ? '0 : ctl_hd_wdata;

  function automatic logic [GA_W-1:0] granule(input logic swp, input logic [LEN_W-1:0] off);
    logic [GA_W-1:0] base;
    base = swp ? GA_W'(HG) : '0;
    return base + GA_W'(off >> 3);
  endfunction

  logic             in_acc;
  logic             e_swp;
  logic [LEN_W-1:0] e_off, e_bytes;
  logic [LEN_W-1:0] r_bytes;
  logic [31:0]      blk;
  logic [32:0]      hdiff, sdiff;
  logic [CW-1:0]    size_r;
  logic [LEN_W+1:0] free_total;
  logic [CNT_W-1:0] rem;

  assign in_stall_o = clr_q || (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign {e_swp, e_off, e_bytes} = ent_q;
  assign r_bytes = fl_rdata[LEN_W-1:0];

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    total_d  = total_q;
    cnt_d    = cnt_q;
    iss_d    = iss_q;
    listed_d = listed_q;
    hnext_d  = hnext_q;
    snext_d  = snext_q;
    chk_d    = chk_q;
    rdi_d    = rdi_q;
    pidx_d   = pidx_q;
    pend_d   = pend_q;
    ent_d    = ent_q;
    swp_d    = swp_q;
    off_d    = off_q;
    bytes_d  = bytes_q;
    st_d     = st_q;
    user_d   = user_q;
    fsw_d    = fsw_q;
    bb_d     = bb_q;
    out_d    = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    fl_we    = 1'b0;
    fl_waddr = '0;
    fl_wdata = '0;
    fl_raddr = '0;
    ctl_hd_we    = 1'b0;
    ctl_hd_waddr = granule(swp_q, off_q);
    ctl_hd_wdata = '0;
    hd_raddr     = granule(swp_q, off_q);
    size_r = (CW'(in_item_i.request_bytes) + CW'(7)) & ~CW'(7);
    blk    = req_q.address - 32'(HEADER_BYTES);
    hdiff  = {1'b0, blk} - {1'b0, heap_base_q};
    sdiff  = {1'b0, blk} - {1'b0, swap_base_q};
    rem    = cnt_q - CNT_W'(1) - CNT_W'(chk_q);
    free_total = (LEN_W+2)'(heap_len_q - hnext_q) + (LEN_W+2)'(swap_len_q - snext_q)
               + (LEN_W+2)'(listed_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d   = in_item_i;
          total_d = (CW'(HEADER_BYTES) + size_r + CW'(7)) & ~CW'(7);
          user_d  = '0;
          fsw_d   = 1'b0;
          bb_d    = '0;
          st_d    = ST_OK;
          iss_d   = '0;
          pend_d  = 1'b0;
          state_d = (in_item_i.opcode == OP_ALLOC) ? S_SCAN : S_FREG;
        end
      end
      S_SCAN: begin
        if (pend_q && (CW'(r_bytes) >= total_q)) begin
          ent_d   = fl_rdata;
          pend_d  = 1'b0;
          state_d = S_FIT;
        end else if (iss_q < cnt_q) begin
          fl_raddr = iss_q[IDX_W-1:0];
          pend_d   = 1'b1;
          chk_d    = iss_q[IDX_W-1:0];
          iss_d    = iss_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_BUMP;
          end
        end
      end
      S_FIT: begin
        swp_d = e_swp;
        off_d = e_off;
        if (CW'(e_bytes) >= total_q + CW'(HEADER_BYTES) + CW'(8)) begin
          fl_we    = 1'b1;
          fl_waddr = chk_q;
          fl_wdata = {e_swp, LEN_W'(CW'(e_off) + total_q), LEN_W'(CW'(e_bytes) - total_q)};
          bytes_d  = LEN_W'(total_q);
          listed_d = listed_q - (LEN_W+1)'(total_q);
          state_d  = S_HW;
        end else begin
          bytes_d  = e_bytes;
          listed_d = listed_q - (LEN_W+1)'(e_bytes);
          cnt_d    = cnt_q - CNT_W'(1);
          iss_d    = rem;
          rdi_d    = chk_q + IDX_W'(1);
          state_d  = (rem != '0) ? S_SHD : S_HW;
        end
      end
      S_SHD: begin
        // Entries below the removed one move up by one place.
        if (pend_q) begin
          fl_we    = 1'b1;
          fl_waddr = pidx_q - IDX_W'(1);
          fl_wdata = fl_rdata;
        end
        if (iss_q != '0) begin
          fl_raddr = rdi_q;
          pend_d   = 1'b1;
          pidx_d   = rdi_q;
          rdi_d    = rdi_q + IDX_W'(1);
          iss_d    = iss_q - CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_HW;
          end
        end
      end
      S_BUMP: begin
        if (CW'(hnext_q) + total_q <= CW'(heap_len_q)) begin
          swp_d   = 1'b0;
          off_d   = hnext_q;
          bytes_d = LEN_W'(total_q);
          hnext_d = LEN_W'(CW'(hnext_q) + total_q);
          state_d = S_HW;
        end else if (CW'(snext_q) + total_q <= CW'(swap_len_q)) begin
          swp_d   = 1'b1;
          off_d   = snext_q;
          bytes_d = LEN_W'(total_q);
          snext_d = LEN_W'(CW'(snext_q) + total_q);
          state_d = S_HW;
        end else begin
          st_d    = ST_NO_MEM;
          state_d = S_RES;
        end
      end
      S_HW: begin
        ctl_hd_we    = 1'b1;
        ctl_hd_wdata = bytes_q;
        user_d  = (swp_q ? swap_base_q : heap_base_q) + 32'(off_q) + 32'(HEADER_BYTES);
        fsw_d   = swp_q;
        bb_d    = 17'(bytes_q);
        state_d = S_RES;
      end
      S_FREG: begin
        state_d = S_RES;
        if (req_q.address == '0) begin
          st_d = ST_OK;
        end else if (req_q.address < 32'(HEADER_BYTES)) begin
          st_d = ST_OUTSIDE;
        end else if (!hdiff[32] && (hdiff < 33'(heap_len_q))) begin
          swp_d = 1'b0;
          off_d = LEN_W'(hdiff);
          if (hdiff[2:0] != 3'd0) st_d = ST_NOT_BLOCK;
          else                    state_d = S_FRD;
        end else if (!sdiff[32] && (sdiff < 33'(swap_len_q))) begin
          swp_d = 1'b1;
          off_d = LEN_W'(sdiff);
          if (sdiff[2:0] != 3'd0) st_d = ST_NOT_BLOCK;
          else                    state_d = S_FRD;
        end else begin
          st_d = ST_OUTSIDE;
        end
      end
      S_FRD: begin
        state_d = S_FHDR;
      end
      S_FHDR: begin
        bytes_d = hd_rdata;
        state_d = S_RES;
        if (hd_rdata == '0) begin
          st_d = ST_NOT_BLOCK;
        end else if ((req_q.request_bytes != '0) &&
                     (CW'(req_q.request_bytes) > CW'(hd_rdata) - CW'(HEADER_BYTES))) begin
          st_d = ST_TOO_LARGE;
        end else begin
          ctl_hd_we = 1'b1;
          if (cnt_q >= CNT_W'(FREE_SLOTS)) begin
            st_d = ST_LEAKED;
          end else begin
            iss_d   = cnt_q;
            rdi_d   = IDX_W'(cnt_q - CNT_W'(1));
            pend_d  = 1'b0;
            state_d = (cnt_q == '0) ? S_PUSH : S_SHU;
          end
        end
      end
      S_SHU: begin
        // The list moves down one place to open the front entry.
        if (pend_q) begin
          fl_we    = 1'b1;
          fl_waddr = pidx_q + IDX_W'(1);
          fl_wdata = fl_rdata;
        end
        if (iss_q != '0) begin
          fl_raddr = rdi_q;
          pend_d   = 1'b1;
          pidx_d   = rdi_q;
          rdi_d    = rdi_q - IDX_W'(1);
          iss_d    = iss_q - CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        fl_we    = 1'b1;
        fl_waddr = '0;
        fl_wdata = {swp_q, off_q, bytes_q};
        cnt_d    = cnt_q + CNT_W'(1);
        listed_d = listed_q + (LEN_W+1)'(bytes_q);
        state_d  = S_RES;
      end
      S_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.status       = st_q;
          out_d.user_address = user_q;
          out_d.swap_grant   = fsw_q;
          out_d.block_bytes  = bb_q;
          out_d.spare_bytes  = 18'(free_total);
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      listed_q    <= '0;
      hnext_q     <= '0;
      snext_q     <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (reinit) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      listed_q    <= '0;
      hnext_q     <= '0;
      snext_q     <= '0;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      listed_q    <= listed_d;
      hnext_q     <= hnext_d;
      snext_q     <= snext_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + GA_W'(1);
        if (clr_addr_q == GA_W'(GDEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    total_q <= total_d;
    chk_q   <= chk_d;
    rdi_q   <= rdi_d;
    pidx_q  <= pidx_d;
    ent_q   <= ent_d;
    swp_q   <= swp_d;
    off_q   <= off_d;
    bytes_q <= bytes_d;
    st_q    <= st_d;
    user_q  <= user_d;
    fsw_q   <= fsw_d;
    bb_q    <= bb_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

>>> rtl/ffba_checker.sv
// Port-level checks of the block allocator and their bind to the top level.
`default_nettype none
module ffba_checker import ffba_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire rsp_t out_item_o,
  input wire logic cfg_we_i
);

  // A held result stays offered with the same contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item dropped or changed while stalled");

  // One request is in work at a time, so an accepted item closes the input.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted again right after an item");

  // A configuration write starts the header clearing pass.
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input open right after a configuration write");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == ST_OK || out_item_o.status == ST_NO_MEM ||
      out_item_o.status == ST_OUTSIDE || out_item_o.status == ST_NOT_BLOCK ||
      out_item_o.status == ST_TOO_LARGE || out_item_o.status == ST_LEAKED))
    else $error("status code out of range");

  // Only a granted block carries a swap flag or a size.
  a_grant_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |->
      !out_item_o.swap_grant && out_item_o.block_bytes == '0 &&
      out_item_o.user_address == '0)
    else $error("failed request reports a grant");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .cfg_we_i    (cfg_we_i)
);
`default_nettype wire

>>> test/first_fit_block_allocator_tb.sv
// Self-checking testbench of the first-fit block allocator: mirror model, stimulus and checks.
`default_nettype none
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int HDR_BYTES   = 40;
  localparam int HEAP_MAX    = 65536;
  localparam int SWAP_SIZE   = 65536;
  localparam int LIST_SLOTS  = 32;
  localparam int HEAP_GRAN   = (HEAP_MAX + 7) / 8;
  localparam int SWAP_GRAN   = (SWAP_SIZE + 7) / 8;
  localparam longint unsigned ADDR_TOP = 64'h1_0000_0000;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    bit              in_swap;
    longint unsigned offset;
    longint unsigned bytes;
  } span_t;

  typedef struct {
    logic [31:0] addr;
    int          body;
  } grant_t;

  // Mirror of the allocator state; predicts one result per accepted request.
  class allocator_mirror;
    longint unsigned heap_base, heap_bytes, swap_base;
    longint unsigned heap_len, swap_len, heap_next, swap_next, listed;
    span_t           spans[$];
    int unsigned     headers[HEAP_GRAN + SWAP_GRAN];
    rsp_t            due_results[$];
    int              errors;
    int              checked;

    function new();
      heap_base  = 0;
      heap_bytes = 0;
      swap_base  = 65536;
      errors     = 0;
      checked    = 0;
      reinit();
    endfunction

    function longint unsigned clip(longint unsigned base, longint unsigned len);
      if (base + len > ADDR_TOP) return ADDR_TOP - base;
      return len;
    endfunction

    function void reinit();
      heap_len  = clip(heap_base, (heap_bytes > HEAP_MAX) ? HEAP_MAX : heap_bytes);
      swap_len  = clip(swap_base, SWAP_SIZE);
      heap_next = 0;
      swap_next = 0;
      listed    = 0;
      spans.delete();
      foreach (headers[i]) headers[i] = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_HEAP_BASE:  heap_base = val;
        CFG_HEAP_BYTES: heap_bytes = val[16:0];
        CFG_SWAP_BASE:  swap_base = val;
        default: return;
      endcase
      reinit();
    endfunction

    function int unsigned granule(bit in_swap, longint unsigned off);
      return (in_swap ? HEAP_GRAN : 0) + int'(off >> 3);
    endfunction

    function rsp_t take_request(req_t r);
      rsp_t            res;
      longint unsigned size, total, off, bytes, blk, addr;
      bit              found, in_swap;
      int unsigned     g;
      res = '0;
      res.status = ST_OK;
      found = 0;
      in_swap = 0;
      off = 0;
      bytes = 0;
      addr = r.address;
      if (r.opcode == OP_ALLOC) begin
        size  = (longint'(r.request_bytes) + 7) & ~64'd7;
        total = (HDR_BYTES + size + 7) & ~64'd7;
        foreach (spans[i]) begin
          if (spans[i].bytes < total) continue;
          found = 1;
          in_swap = spans[i].in_swap;
          off = spans[i].offset;
          if (spans[i].bytes >= total + HDR_BYTES + 8) begin
            bytes = total;
            spans[i].offset += total;
            spans[i].bytes -= total;
          end else begin
            bytes = spans[i].bytes;
            spans.delete(i);
          end
          listed -= bytes;
          break;
        end
        if (!found && heap_next + total <= heap_len) begin
          found = 1;
          off = heap_next;
          bytes = total;
          heap_next += total;
        end else if (!found && swap_next + total <= swap_len) begin
          found = 1;
          in_swap = 1;
          off = swap_next;
          bytes = total;
          swap_next += total;
        end
        if (!found) begin
          res.status = ST_NO_MEM;
        end else begin
          headers[granule(in_swap, off)] = int'(bytes);
          res.user_address = 32'((in_swap ? swap_base : heap_base) + off + HDR_BYTES);
          res.swap_grant   = in_swap;
          res.block_bytes  = bytes[16:0];
        end
      end else if (addr != 0) begin
        if (addr < HDR_BYTES) begin
          res.status = ST_OUTSIDE;
        end else begin
          blk = addr - HDR_BYTES;
          if (blk >= heap_base && blk - heap_base < heap_len) begin
            in_swap = 0;
            off = blk - heap_base;
            found = 1;
          end else if (blk >= swap_base && blk - swap_base < swap_len) begin
            in_swap = 1;
            off = blk - swap_base;
            found = 1;
          end
          if (!found) begin
            res.status = ST_OUTSIDE;
          end else if (off[2:0] != 0) begin
            res.status = ST_NOT_BLOCK;
          end else begin
            g = granule(in_swap, off);
            if (headers[g] == 0) begin
              res.status = ST_NOT_BLOCK;
            end else if (r.request_bytes != 0 &&
                         longint'(r.request_bytes) > longint'(headers[g]) - HDR_BYTES) begin
              res.status = ST_TOO_LARGE;
            end else begin
              bytes = headers[g];
              headers[g] = 0;
              if (spans.size() >= LIST_SLOTS) begin
                res.status = ST_LEAKED;
              end else begin
                spans.push_front('{in_swap, off, bytes});
                listed += bytes;
              end
            end
          end
        end
      end
      res.spare_bytes = 18'((heap_len - heap_next) + (swap_len - swap_next) + listed);
      due_results.push_back(res);
      return res;
    endfunction

    task report(string field, longint unsigned got, longint unsigned want);
      errors++;
      $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h", checked, field, got, want);
    endtask

    task match_result(rsp_t got);
      rsp_t want;
      if (due_results.size() == 0) begin
        report("unexpected result", 1, 0);
        checked++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.user_address !== want.user_address)
        report("user_address", got.user_address, want.user_address);
      if (got.swap_grant !== want.swap_grant)
        report("swap_grant", got.swap_grant, want.swap_grant);
      if (got.block_bytes !== want.block_bytes)
        report("block_bytes", got.block_bytes, want.block_bytes);
      if (got.spare_bytes !== want.spare_bytes)
        report("spare_bytes", got.spare_bytes, want.spare_bytes);
      checked++;
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  req_t                 in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  rsp_t                 out_item_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  allocator_mirror mirror = new();
  grant_t          live[$];
  int              sent_items = 0;
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              cycles = 0;

  first_fit_block_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("first_fit_block_allocator regression: fail");
      $finish;
    end
  end

  // Receiver: random stall at the falling edge, result taken at the rising edge.
  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) mirror.match_result(out_item_o);
  end

  task automatic send_item(req_t r, output rsp_t want);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = mirror.take_request(r);
    sent_items++;
  endtask

  task automatic alloc_item(int bytes);
    req_t r;
    rsp_t want;
    r = '{OP_ALLOC, 16'(bytes), $urandom()};
    send_item(r, want);
    if (want.status == ST_OK) live.push_back('{want.user_address, want.block_bytes - HDR_BYTES});
  endtask

  task automatic free_item(int bytes, logic [31:0] addr);
    req_t r;
    rsp_t want;
    r = '{OP_FREE, 16'(bytes), addr};
    send_item(r, want);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mirror.configure(idx, val);
    live.delete();
  endtask

  task automatic directed_items();
    grant_t a, b, c;
    alloc_item(0);
    alloc_item(1);
    alloc_item(65535);
    alloc_item(2000);
    a = live[0];
    b = live[1];
    c = live[live.size() - 1];
    free_item(0, 32'h0);
    free_item(0, 32'd39);
    free_item(0, 32'hFFFF_FFFF);
    free_item(0, a.addr + 4);
    free_item(b.body + 1, b.addr);
    free_item(a.body, a.addr);
    free_item(0, a.addr);
    alloc_item(0);
    free_item(0, b.addr);
    alloc_item(8);
    free_item(c.body, c.addr);
    free_item(16'hFFFF, live[live.size() - 1].addr);
    live.delete();
  endtask

  // Many small blocks, then all of them freed so the list overflows.
  task automatic fill_and_release();
    grant_t g;
    repeat (40) alloc_item($urandom_range(0, 24));
    while (live.size() > 0) begin
      g = live.pop_front();
      free_item(0, g.addr);
    end
  endtask

  task automatic random_items(int count);
    int     stop, pick, k, sz;
    grant_t g;
    stop = sent_items + count;
    while (sent_items < stop) begin
      case ((sent_items / 60) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) == 0) begin
        fill_and_release();
      end else if (pick < 45 || live.size() == 0 && pick < 85) begin
        k = $urandom_range(0, 9);
        if (k < 7) sz = $urandom_range(0, 200);
        else if (k < 9) sz = $urandom_range(0, 2000);
        else sz = $urandom_range(0, 65535);
        alloc_item(sz);
      end else if (pick < 85) begin
        k = $urandom_range(0, live.size() - 1);
        g = live[k];
        // Now and then the block stays in the list so that it is freed twice.
        if ($urandom_range(0, 19) != 0) live.delete(k);
        k = $urandom_range(0, 19);
        if (k < 12) sz = 0;
        else if (k < 17) sz = g.body;
        else if (k < 19) sz = $urandom_range(1, g.body);
        else sz = $urandom_range(g.body + 1, 65535);
        free_item(sz, g.addr);
      end else begin
        k = $urandom_range(0, 5);
        case (k)
          0: free_item(0, 32'h0);
          1: free_item($urandom_range(0, 65535), $urandom_range(1, HDR_BYTES - 1));
          2: free_item($urandom_range(0, 65535), $urandom());
          3: free_item(0, live.size() ? live[0].addr + $urandom_range(1, 7) : $urandom());
          4: free_item(0, live.size() ? live[0].addr + 8 : $urandom());
          default: free_item(0, 32'(mirror.swap_base + HDR_BYTES + 8 * $urandom_range(0, 63)));
        endcase
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    random_items(60);
    cfg_write(CFG_HEAP_BYTES, 32'd2048);
    directed_items();
    random_items(200);
    cfg_write(CFG_HEAP_BASE, 32'h1000_0000);
    random_items(180);
    cfg_write(CFG_HEAP_BYTES, 32'h1_FFFF);
    random_items(200);
    cfg_write(CFG_SWAP_BASE, 32'hFFFF_FC00);
    random_items(150);
    cfg_write(CFG_HEAP_BASE, 32'hFFFF_F000);
    random_items(150);
    cfg_write(CFG_HEAP_BYTES, 32'd0);
    random_items(90);
    cfg_write(CFG_SWAP_BASE, 32'h0);
    random_items(100);
    drain();

    $display("covered %0d requests and %0d results over eight register settings,",
             sent_items, mirror.checked);
    $display("including list overflow, clipped and overlapping regions and bad frees");
    if (mirror.errors == 0 && mirror.due_results.size() == 0) begin
      $display("first_fit_block_allocator regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mirror.errors,
               mirror.due_results.size());
      $display("first_fit_block_allocator regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
